// ----- hdl/envelope_swept_resonant_lowpass_macros.svh -----
// Assertion macros shared by the filter modules.
`ifndef ENVELOPE_SWEPT_RESONANT_LOWPASS_MACROS_SVH
`define ENVELOPE_SWEPT_RESONANT_LOWPASS_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ESRL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define ESRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/esrl_pkg.sv -----
package esrl_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_NOTE_ON = 2'd1,
		CMD_LOAD    = 2'd2
	} cmd_t;

	// Width of the table entry index field
	localparam int ENTRY_W = 10;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CNT_W = 3;

	typedef struct packed {
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} q_status_t;

endpackage

// ----- hdl/esrl_fifo.sv -----
module esrl_fifo #(
	parameter int WIDTH = 68
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [WIDTH-1:0]         push_data,
	input  logic                     pop,
	output logic [WIDTH-1:0]         pop_data,
	output esrl_pkg::q_status_t      status
);

	logic [WIDTH-1:0]               slots_q [esrl_pkg::Q_DEPTH];
	logic [esrl_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [esrl_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [esrl_pkg::Q_CNT_W-1:0]   count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_data;
	end

	assign pop_data     = slots_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.count = count_q;

endmodule

// ----- hdl/esrl_front.sv -----
`include "envelope_swept_resonant_lowpass_macros.svh"

module esrl_front #(
	parameter int ENV_LENGTH    = 65536,
	parameter int ENV_STEP_BITS = 6,
	parameter int SAMPLE_WIDTH  = 16,
	parameter int COEF_WIDTH    = 18,
	localparam int QW           = SAMPLE_WIDTH + 3 * COEF_WIDTH + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        in_cmd,
	input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
	input  logic [esrl_pkg::ENTRY_W-1:0]      in_index,
	input  logic signed [COEF_WIDTH-1:0]      in_coef_a,
	input  logic signed [COEF_WIDTH-1:0]      in_coef_b,
	input  esrl_pkg::q_status_t               q_status,
	output logic                              q_push,
	output logic [QW-1:0]                     q_data
);

	localparam int TABLE_DEPTH = ((ENV_LENGTH - 1) >> ENV_STEP_BITS) + 1;
	localparam int MEM_MAX     = 1 << esrl_pkg::ENTRY_W;
	localparam int MEM_DEPTH   = (TABLE_DEPTH > MEM_MAX) ? MEM_MAX : TABLE_DEPTH;
	localparam int AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int POS_W       = $clog2(ENV_LENGTH);
	localparam int FS          = COEF_WIDTH - 2;
	localparam int CW          = COEF_WIDTH;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(ENV_LENGTH - 1);
	localparam logic signed [CW+1:0] COEF_ONE = (CW + 2)'(1) <<< FS;

	logic [2*CW-1:0]               coef_mem [MEM_DEPTH];
	logic [POS_W-1:0]              pos_q;
	logic                          valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic [2*CW-1:0]               coef_s1;

	logic            accept;
	logic            is_sample;
	logic            is_note;
	logic            is_load;
	logic            load_ok;
	logic [AW-1:0]   rd_addr;
	logic signed [CW-1:0] a_s1;
	logic signed [CW-1:0] b_s1;
	logic signed [CW+1:0] c_s1;

	// room check: queue fill plus the item in stage 1 stays within depth
	assign in_ready = ((esrl_pkg::Q_CNT_W + 1)'(q_status.count)
		+ (esrl_pkg::Q_CNT_W + 1)'(valid_s1)) < (esrl_pkg::Q_CNT_W + 1)'(esrl_pkg::Q_DEPTH);
	assign accept = in_valid && in_ready;

	// classify the beat
	always_comb begin
		is_sample = 1'b0;
		is_note   = 1'b0;
		is_load   = 1'b0;
		unique case (esrl_pkg::cmd_t'(in_cmd))
			esrl_pkg::CMD_SAMPLE:  is_sample = 1'b1;
			esrl_pkg::CMD_NOTE_ON: is_note   = 1'b1;
			esrl_pkg::CMD_LOAD:    is_load   = 1'b1;
			default: ;
		endcase
	end

	assign load_ok = is_load && (32'(in_index) < TABLE_DEPTH);
	assign rd_addr = AW'(pos_q >> ENV_STEP_BITS);

	// envelope position: restart on note-on, step per sample, hold at end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && is_sample;
			if (accept && is_note) begin
				pos_q <= '0;
			end else if (accept && is_sample && (pos_q != POS_LAST)) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// coefficient memory, one write or one registered read per beat
	always_ff @(posedge clk) begin
		if (accept && load_ok) begin
			coef_mem[AW'(in_index)] <= {in_coef_b, in_coef_a};
		end
		if (accept && is_sample) begin
			coef_s1 <= coef_mem[rd_addr];
			x_s1    <= in_sample;
		end
	end

	// input weight c = 1 - a - b, exact at two extra bits
	assign a_s1 = $signed(coef_s1[CW-1:0]);
	assign b_s1 = $signed(coef_s1[2*CW-1:CW]);
	assign c_s1 = COEF_ONE - (CW + 2)'(a_s1) - (CW + 2)'(b_s1);

	assign q_push = valid_s1;
	assign q_data = {c_s1, b_s1, a_s1, x_s1};

	`ESRL_ASSERT_SAME(a_front_no_overflow, clk, arst_n, valid_s1, q_status.count < (esrl_pkg::Q_CNT_W)'(esrl_pkg::Q_DEPTH), "queue push while full")

endmodule

// ----- hdl/esrl_back.sv -----
`include "envelope_swept_resonant_lowpass_macros.svh"

module esrl_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 18,
	localparam int QW          = SAMPLE_WIDTH + 3 * COEF_WIDTH + 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  esrl_pkg::q_status_t             q_status,
	input  logic [QW-1:0]                   q_data,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]  out_sample
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int CW    = COEF_WIDTH;
	localparam int FS    = CW - 2;
	localparam int PRW   = CW + SW + 2;
	localparam int ACC_W = (PRW + 2 > 64) ? 64 : PRW + 2;
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (FS - 1);

	logic signed [SW-1:0]   x;
	logic signed [CW-1:0]   a;
	logic signed [CW-1:0]   b;
	logic signed [CW+1:0]   c;

	logic                   valid_s1;
	logic signed [PRW-1:0]  pa_s1;
	logic signed [PRW-1:0]  pb_s1;
	logic signed [PRW-1:0]  pc_s1;

	logic signed [SW-1:0]   y1_q;
	logic signed [SW-1:0]   y2_q;
	logic signed [SW-1:0]   out_q;
	logic                   out_valid_q;

	logic                   done;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] shifted;
	logic [ACC_W-SW:0]      upper;
	logic                   fits;
	logic signed [SW-1:0]   y_sat;

	// unpack queue entry
	assign x = $signed(q_data[SW-1:0]);
	assign a = $signed(q_data[SW+CW-1:SW]);
	assign b = $signed(q_data[SW+2*CW-1:SW+CW]);
	assign c = $signed(q_data[SW+3*CW+1:SW+2*CW]);

	// take a new item only once the previous output is fed back
	assign q_pop = !q_status.empty && !valid_s1;
	assign done  = valid_s1 && (!out_valid_q || out_ready);

	// stage 1: three products
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pa_s1 <= a * y1_q;
			pb_s1 <= b * y2_q;
			pc_s1 <= c * x;
		end
	end

	// stage 2: sum, round to nearest, saturate
	assign acc     = ACC_W'(pa_s1) + ACC_W'(pb_s1) + ACC_W'(pc_s1) + ROUND;
	assign shifted = acc >>> FS;
	assign upper   = shifted[ACC_W-1:SW-1];
	assign fits    = (&upper) || !(|upper);
	assign y_sat   = fits ? shifted[SW-1:0]
		: {shifted[ACC_W-1], {(SW - 1){~shifted[ACC_W-1]}}};

	// delay line, output register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			y1_q        <= '0;
			y2_q        <= '0;
		end else begin
			if (q_pop)     valid_s1 <= 1'b1;
			else if (done) valid_s1 <= 1'b0;
			if (done) begin
				out_valid_q <= 1'b1;
				y1_q        <= y_sat;
				y2_q        <= y1_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) out_q <= y_sat;
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

	`ESRL_ASSERT_NEXT(a_back_pop_spacing, clk, arst_n, q_pop, !q_pop, "pops one cycle apart")
	`ESRL_ASSERT_NEXT(a_back_fb_matches_out, clk, arst_n, done, (y1_q == out_q) && out_valid_q, "feedback differs from output")
	`ESRL_ASSERT_NEXT(a_back_delay_shift, clk, arst_n, done, y2_q == $past(y1_q), "delay line did not shift")

endmodule

// ----- hdl/envelope_swept_resonant_lowpass.sv -----
// Channel     | Dir | Payload
// ------------+-----+--------------------------------------------------------
// s_axis      | in  | tuser: cmd; tdata: sample_in, entry_index, coef_a, coef_b
// m_axis      | out | tdata: sample_out
//
// A sample beat is accepted every cycle while the queue has room; the filter
// core takes a new sample only after the previous one is done, set by the y1
// feedback through the product and sum stages. From accept to output a sample
// passes the stage 1 register, the queue, the product stage and the output
// register. Note-on and load beats produce no output. Output stalls hold the
// result register and let the queue fill before the input deasserts tready.
// Reset clears the delay line and envelope, not the coefficient table.
module envelope_swept_resonant_lowpass #(
	parameter int ENV_LENGTH    = 65536,
	parameter int ENV_STEP_BITS = 6,
	parameter int SAMPLE_WIDTH  = 16,
	parameter int COEF_WIDTH    = 18,
	localparam int IN_W  = ((SAMPLE_WIDTH + esrl_pkg::ENTRY_W + 2 * COEF_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// low to high: sample_in, entry_index, coef_a_value, coef_b_value, zero pad
	input  logic [IN_W-1:0]  s_axis_tdata,
	// cmd
	input  logic [1:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// low to high: sample_out, zero pad
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = COEF_WIDTH;
	localparam int EW  = esrl_pkg::ENTRY_W;
	localparam int QW  = SW + 3 * CW + 2;

	esrl_pkg::q_status_t   q_status;
	logic                  q_push;
	logic                  q_pop;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;
	logic signed [SW-1:0]  out_sample;

	// front: classify, envelope, coefficient table
	esrl_front #(
		.ENV_LENGTH    (ENV_LENGTH),
		.ENV_STEP_BITS (ENV_STEP_BITS),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.COEF_WIDTH    (COEF_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_sample ($signed(s_axis_tdata[SW-1:0])),
		.in_index  (s_axis_tdata[SW+EW-1:SW]),
		.in_coef_a ($signed(s_axis_tdata[SW+EW+CW-1:SW+EW])),
		.in_coef_b ($signed(s_axis_tdata[SW+EW+2*CW-1:SW+EW+CW])),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// queue of pending samples with their coefficients
	esrl_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.status    (q_status)
	);

	// back: multiply-accumulate and feedback
	esrl_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (out_sample)
	);

	assign m_axis_tdata = OUT_W'(unsigned'(out_sample));

endmodule
